// ----- rtl/core/sxl_pkg.sv -----
// sxl_pkg: shared types, codes and helper functions of the s-expression lexer.
// Used by sxl_front, sxl_queue, sxl_back and sexpr_token_lexer; no dependencies.
package sxl_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_HEX  = 2'd1,
        MODE_STR  = 2'd2,
        MODE_ESC  = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        K_OPEN    = 4'd0,
        K_CLOSE   = 4'd1,
        K_VAR     = 4'd2,
        K_TYPE    = 4'd3,
        K_FUNC    = 4'd4,
        K_INT     = 4'd5,
        K_UINT    = 4'd6,
        K_FLOAT   = 4'd7,
        K_OPCODE  = 4'd8,
        K_STRCHAR = 4'd9,
        K_STREND  = 4'd10,
        K_NUL     = 4'd11,
        K_UNEXP   = 4'd12,
        K_BADESC  = 4'd13,
        K_UNTERM  = 4'd14
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] value;
    } t_token;

    // one queue entry: the tokens caused by one byte
    typedef struct packed {
        logic   two;
        t_token tok0;
        t_token tok1;
    } t_job;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BEL    = 8'h07;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] CH_LI     = 8'h69;
    localparam logic [7:0] CH_LN     = 8'h6E;
    localparam logic [7:0] CH_LR     = 8'h72;
    localparam logic [7:0] CH_LT     = 8'h74;
    localparam logic [7:0] CH_LU     = 8'h75;
    localparam logic [7:0] CH_LV     = 8'h76;
    localparam logic [7:0] CH_LX     = 8'h78;

    // {valid, digit}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            r = {1'b1, 4'(c - CH_ZERO)};
        end else if (c >= CH_UA && c <= CH_UF) begin
            r = {1'b1, 4'(c - CH_UA + 8'd10)};
        end else if (c >= CH_LA && c <= CH_LF_HEX) begin
            r = {1'b1, 4'(c - CH_LA + 8'd10)};
        end
        return r;
    endfunction

    // K_OPEN means "not a prefix letter"
    function automatic t_kind prefix_kind(input logic [7:0] c);
        t_kind k;
        case (c)
            CH_LV:     k = K_VAR;
            CH_LT:     k = K_TYPE;
            CH_LF_HEX: k = K_FUNC;
            CH_LI:     k = K_INT;
            CH_LU:     k = K_UINT;
            CH_LR:     k = K_FLOAT;
            CH_LX:     k = K_OPCODE;
            default:   k = K_OPEN;
        endcase
        return k;
    endfunction

    // {valid, decoded char}
    function automatic logic [8:0] esc_char(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            CH_LN:     r = {1'b1, CH_LF};
            CH_LV:     r = {1'b1, CH_VT};
            CH_LT:     r = {1'b1, CH_TAB};
            CH_LR:     r = {1'b1, CH_CR};
            CH_BSLASH: r = {1'b1, CH_BSLASH};
            CH_APOS:   r = {1'b1, CH_APOS};
            CH_QUOTE:  r = {1'b1, CH_QUOTE};
            CH_ZERO:   r = {1'b1, CH_NUL};
            CH_LA:     r = {1'b1, CH_BEL};
            default:   r = {1'b0, c};
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/sxl_front.sv -----
// sxl_front: lexer state machine; classifies one byte per cycle while i_accept is high and builds
// the job of up to two tokens it causes. Depends on sxl_pkg.
module sxl_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_text_byte,
    input  logic          i_end_of_text,
    output logic          o_push,
    output sxl_pkg::t_job o_job
);

    sxl_pkg::t_mode             r_mode, n_mode;
    sxl_pkg::t_kind             r_pending, n_pending;
    logic [63:0]                r_acc, n_acc;
    logic [sxl_pkg::LENGTH_BITS-1:0] r_len, n_len;

    // idle-mode classification of the current byte
    logic           idle_emit;
    sxl_pkg::t_token idle_tok;
    sxl_pkg::t_mode idle_mode;
    logic           idle_hex;
    logic           idle_str;
    sxl_pkg::t_kind pk;
    logic [4:0]     hd;
    logic [8:0]     esc;
    logic [63:0]    byte_val;

    logic [1:0]      cnt;
    sxl_pkg::t_token tok0, tok1;
    logic            eot_hit;
    sxl_pkg::t_token eot_tok;

    always_comb begin
        pk        = sxl_pkg::prefix_kind(i_text_byte);
        hd        = sxl_pkg::hex_digit(i_text_byte);
        esc       = sxl_pkg::esc_char(i_text_byte);
        byte_val  = 64'(i_text_byte);
        idle_emit = 1'b0;
        idle_tok  = '{kind: sxl_pkg::K_OPEN, value: '0};
        idle_mode = sxl_pkg::MODE_IDLE;
        idle_hex  = 1'b0;
        idle_str  = 1'b0;
        if (i_text_byte == sxl_pkg::CH_SPACE || i_text_byte == sxl_pkg::CH_TAB ||
            i_text_byte == sxl_pkg::CH_VT || i_text_byte == sxl_pkg::CH_LF) begin
            idle_emit = 1'b0;
        end else if (i_text_byte == sxl_pkg::CH_LPAREN) begin
            idle_emit = 1'b1;
        end else if (i_text_byte == sxl_pkg::CH_RPAREN) begin
            idle_emit = 1'b1;
            idle_tok  = '{kind: sxl_pkg::K_CLOSE, value: '0};
        end else if (i_text_byte == sxl_pkg::CH_NUL) begin
            idle_emit = 1'b1;
            idle_tok  = '{kind: sxl_pkg::K_NUL, value: '0};
        end else if (pk != sxl_pkg::K_OPEN) begin
            idle_hex  = 1'b1;
            idle_mode = sxl_pkg::MODE_HEX;
        end else if (i_text_byte == sxl_pkg::CH_QUOTE) begin
            idle_str  = 1'b1;
            idle_mode = sxl_pkg::MODE_STR;
        end else begin
            idle_emit = 1'b1;
            idle_tok  = '{kind: sxl_pkg::K_UNEXP, value: byte_val};
        end
    end

    always_comb begin
        n_mode    = r_mode;
        n_pending = r_pending;
        n_acc     = r_acc;
        n_len     = r_len;
        cnt       = 2'd0;
        tok0      = '{kind: sxl_pkg::K_OPEN, value: '0};
        tok1      = '{kind: sxl_pkg::K_OPEN, value: '0};
        eot_hit   = 1'b0;
        eot_tok   = '{kind: sxl_pkg::K_OPEN, value: '0};

        case (r_mode)
            sxl_pkg::MODE_HEX: begin
                if (hd[4]) begin
                    n_acc = {r_acc[59:0], hd[3:0]};
                end else begin
                    // close the pending token, then treat the byte as in idle
                    tok0   = '{kind: r_pending, value: r_acc};
                    cnt    = 2'd1;
                    n_mode = idle_mode;
                    if (idle_emit) begin
                        tok1 = idle_tok;
                        cnt  = 2'd2;
                    end
                    if (idle_hex) begin
                        n_pending = pk;
                        n_acc     = '0;
                    end
                    if (idle_str) begin
                        n_len = '0;
                    end
                end
            end
            sxl_pkg::MODE_STR: begin
                if (i_text_byte == sxl_pkg::CH_BSLASH) begin
                    n_mode = sxl_pkg::MODE_ESC;
                end else if (i_text_byte == sxl_pkg::CH_QUOTE) begin
                    tok0   = '{kind: sxl_pkg::K_STREND, value: 64'(r_len)};
                    cnt    = 2'd1;
                    n_mode = sxl_pkg::MODE_IDLE;
                end else begin
                    tok0 = '{kind: sxl_pkg::K_STRCHAR, value: byte_val};
                    cnt  = 2'd1;
                    if (r_len != '1) n_len = r_len + 1'b1;
                end
            end
            sxl_pkg::MODE_ESC: begin
                cnt = 2'd1;
                if (esc[8]) begin
                    n_mode = sxl_pkg::MODE_STR;
                    tok0   = '{kind: sxl_pkg::K_STRCHAR, value: 64'(esc[7:0])};
                    if (r_len != '1) n_len = r_len + 1'b1;
                end else begin
                    n_mode = sxl_pkg::MODE_IDLE;
                    tok0   = '{kind: sxl_pkg::K_BADESC, value: byte_val};
                end
            end
            default: begin
                n_mode = idle_mode;
                if (idle_emit) begin
                    tok0 = idle_tok;
                    cnt  = 2'd1;
                end
                if (idle_hex) begin
                    n_pending = pk;
                    n_acc     = '0;
                end
                if (idle_str) begin
                    n_len = '0;
                end
            end
        endcase

        // end of text flushes a hex token or reports an open string
        if (i_end_of_text) begin
            if (n_mode == sxl_pkg::MODE_HEX) begin
                eot_hit = 1'b1;
                eot_tok = '{kind: n_pending, value: n_acc};
            end else if (n_mode == sxl_pkg::MODE_STR || n_mode == sxl_pkg::MODE_ESC) begin
                eot_hit = 1'b1;
                eot_tok = '{kind: sxl_pkg::K_UNTERM, value: 64'(n_len)};
            end
            n_mode = sxl_pkg::MODE_IDLE;
        end
        if (eot_hit) begin
            if (cnt == 2'd0) begin
                tok0 = eot_tok;
            end else begin
                tok1 = eot_tok;
            end
            cnt = cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= sxl_pkg::MODE_IDLE;
            r_pending <= sxl_pkg::K_OPEN;
            r_acc     <= '0;
            r_len     <= '0;
        end else if (i_accept) begin
            r_mode    <= n_mode;
            r_pending <= n_pending;
            r_acc     <= n_acc;
            r_len     <= n_len;
        end
    end

    assign o_push = i_accept && (cnt != 2'd0);
    assign o_job  = '{two: (cnt == 2'd2), tok0: tok0, tok1: tok1};

endmodule

// ----- rtl/core/sxl_queue.sv -----
// sxl_queue: short job queue between the lexer front and the token back end.
// Depends on sxl_pkg.
module sxl_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sxl_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_head_valid,
    output sxl_pkg::t_job o_head
);

    sxl_pkg::t_job               r_mem [sxl_pkg::QDEPTH];
    logic [sxl_pkg::QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [sxl_pkg::QCNT_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full       = (r_count == sxl_pkg::QCNT_W'(sxl_pkg::QDEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sxl_pkg::QCNT_W'(sxl_pkg::QDEPTH))
        else $error("job queue count beyond depth");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("job queue popped while empty");

endmodule

// ----- rtl/core/sxl_back.sv -----
// sxl_back: takes jobs from the queue and gives out their tokens one per
// cycle while i_stall is low, through a registered output. Depends on sxl_pkg.
module sxl_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_valid,
    input  sxl_pkg::t_job i_head,
    output logic          o_pop,
    input  logic          i_stall,
    output logic          o_valid,
    output logic [3:0]    o_token_kind,
    output logic [63:0]   o_token_value,
    output logic          o_last_of_run
);

    logic            r_valid;
    logic            r_phase;   // 1: first token of the head job already out
    sxl_pkg::t_kind  r_kind;
    logic [63:0]     r_value;
    logic            r_last;
    logic            load;

    assign load  = !r_valid || !i_stall;
    assign o_pop = load && i_head_valid && (r_phase || !i_head.two);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else if (load) begin
            r_valid <= i_head_valid;
            if (i_head_valid) begin
                r_phase <= !r_phase && i_head.two;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_head_valid) begin
            if (r_phase) begin
                r_kind  <= i_head.tok1.kind;
                r_value <= i_head.tok1.value;
                r_last  <= 1'b1;
            end else begin
                r_kind  <= i_head.tok0.kind;
                r_value <= i_head.tok0.value;
                r_last  <= !i_head.two;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_token_kind  = r_kind;
    assign o_token_value = r_value;
    assign o_last_of_run = r_last;

    // the second token sits in the same queue entry, so it follows as soon as the output is not stalled
    a_pair_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_last && !i_stall |=> r_valid)
        else $error("second token of a byte did not follow");

endmodule

// ----- rtl/core/sexpr_token_lexer.sv -----
// sexpr_token_lexer: s-expression lexer, one text byte per transaction in,
// one token per transaction out. Uses sxl_pkg, sxl_front, sxl_queue, sxl_back.
// Throughput: one byte per cycle while the job queue is not full; one token per
// cycle out of the single output register while i_out_stall is low. A byte's tokens
// pass through the 4-entry job queue and then the output register; the queue absorbs
// the bursts of bytes that yield two tokens. Reset (i_rst_n, synchronous, active
// low) returns the lexer to idle and empties queue and output at once.
module sexpr_token_lexer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    // token output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_token_kind,
    output logic [63:0] o_token_value,
    output logic        o_last_of_run
);

    logic          in_accept;   // input transaction completes this edge
    logic          q_full;
    logic          push;
    sxl_pkg::t_job job;
    logic          pop;
    logic          head_valid;
    sxl_pkg::t_job head;

    // stall whenever the queue is full, even for a byte that would push nothing;
    // the stall then comes straight from the queue count register
    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    // front: state machine, classification, token building
    sxl_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_push        (push),
        .o_job         (job)
    );

    // decoupling queue: bytes that emit nothing never enter it
    sxl_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (job),
        .i_pop        (pop),
        .o_full       (q_full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // back: serializes each job's tokens into the output register
    sxl_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (head_valid),
        .i_head        (head),
        .o_pop         (pop),
        .i_stall       (i_out_stall),
        .o_valid       (o_out_valid),
        .o_token_kind  (o_token_kind),
        .o_token_value (o_token_value),
        .o_last_of_run (o_last_of_run)
    );

endmodule
